>>> src/assert_macros.svh
// Assertion helpers for concurrent checks on a clock with active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> src/i2a_pkg.sv
`timescale 1ns / 1ps

package i2a_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IN_WIDTH    = 32;
    localparam int RADIX_W     = 5;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;

    localparam int DIV_STEP    = 8;
    localparam int DIV_CHUNKS  = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W       = DIV_CHUNKS * DIV_STEP;
    localparam int DIV_CW      = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;

    localparam int DIG_AW      = $clog2(VALUE_WIDTH);

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FETCH,
        S_EMIT
    } t_state;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] b;
        if (r < RADIX_MIN) begin
            b = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            b = RADIX_MAX;
        end else begin
            b = r;
        end
        return b;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic lower);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else if (lower) begin
            c = CHAR_LOW_A + CHAR_W'(d) - 8'd10;
        end else begin
            c = CHAR_UP_A + CHAR_W'(d) - 8'd10;
        end
        return c;
    endfunction

endpackage

>>> src/integer_to_radix_ascii.sv
`timescale 1ns / 1ps
// Integer to ASCII conversion in a base from 2 to 16.
// Input channel (i_in_valid / o_in_ready) takes one beat: value, radix, signed or
// unsigned mode and letter case. Radix below 2 acts as 2, above 16 as 16.
// Output channel (o_out_valid / i_out_ready) gives one character per beat, most
// significant first, with a leading '-' for a negative signed value;
// o_last_char marks the final beat of the number.
// Digits come from a shared divider that retires 8 quotient bits per cycle and
// yields one digit per divide. Digits go into a small buffer and are read back
// in reverse order with a registered read.
// The input channel is ready again once the last character sits in the output
// register. A stalled receiver holds the output register and freezes emission.
// Reset clears the sequencer and the output valid; no result is pending after it.

module integer_to_radix_ascii (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [i2a_pkg::IN_WIDTH-1:0]     i_value_bits,
    input  logic [i2a_pkg::RADIX_W-1:0]      i_radix,
    input  logic                             i_unsigned_mode,
    input  logic                             i_lower_case,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [i2a_pkg::CHAR_W-1:0]       o_ascii_char,
    output logic                             o_last_char
);

    i2a_pkg::t_state                    r_state;
    i2a_pkg::t_state                    n_state;
    logic [i2a_pkg::DIG_AW-1:0]         r_wr_idx;
    logic [i2a_pkg::DIG_AW-1:0]         n_wr_idx;
    logic [i2a_pkg::DIG_AW-1:0]         r_ptr;
    logic [i2a_pkg::DIG_AW-1:0]         n_ptr;
    logic                               r_sign;
    logic                               n_sign;
    logic [i2a_pkg::RADIX_W-1:0]        r_base;
    logic [i2a_pkg::RADIX_W-1:0]        n_base;
    logic                               r_lower;
    logic                               n_lower;
    logic                               r_out_valid;
    logic                               n_out_valid;
    logic [i2a_pkg::CHAR_W-1:0]         r_out_char;
    logic [i2a_pkg::CHAR_W-1:0]         n_out_char;
    logic                               r_out_last;
    logic                               n_out_last;
    logic [i2a_pkg::DIGIT_W-1:0]        r_mem [i2a_pkg::VALUE_WIDTH];
    logic [i2a_pkg::DIGIT_W-1:0]        r_rd_data;

    logic [i2a_pkg::VALUE_WIDTH-1:0]    in_val;
    logic                               in_neg;
    logic [i2a_pkg::VALUE_WIDTH-1:0]    in_mag;
    logic [i2a_pkg::RADIX_W-1:0]        in_base;
    logic                               div_start;
    logic [i2a_pkg::VALUE_WIDTH-1:0]    div_dividend;
    logic [i2a_pkg::RADIX_W-1:0]        div_base;
    logic                               div_done;
    logic [i2a_pkg::VALUE_WIDTH-1:0]    div_quo;
    logic [i2a_pkg::DIGIT_W-1:0]        div_rem;
    logic                               mem_we;
    logic                               out_load;

    assign in_val  = i2a_pkg::VALUE_WIDTH'(i_value_bits);
    assign in_neg  = !i_unsigned_mode && in_val[i2a_pkg::VALUE_WIDTH-1];
    assign in_mag  = in_neg ? (~in_val + i2a_pkg::VALUE_WIDTH'(1)) : in_val;
    assign in_base = i2a_pkg::clamp_radix(i_radix);

    assign o_in_ready   = (r_state == i2a_pkg::S_IDLE);
    assign div_dividend = (r_state == i2a_pkg::S_IDLE) ? in_mag : div_quo;
    assign div_base     = (r_state == i2a_pkg::S_IDLE) ? in_base : r_base;

    i2a_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_base      (div_base),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_wr_idx    = r_wr_idx;
        n_ptr       = r_ptr;
        n_sign      = r_sign;
        n_base      = r_base;
        n_lower     = r_lower;
        div_start   = 1'b0;
        mem_we      = 1'b0;
        out_load    = 1'b0;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        unique case (r_state)
            i2a_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    div_start = 1'b1;
                    n_wr_idx  = '0;
                    n_sign    = in_neg;
                    n_base    = in_base;
                    n_lower   = i_lower_case;
                    n_state   = i2a_pkg::S_DIV;
                end
            end
            i2a_pkg::S_DIV: begin
                if (div_done) begin
                    mem_we   = 1'b1;
                    n_wr_idx = r_wr_idx + i2a_pkg::DIG_AW'(1);
                    if (div_quo == '0) begin
                        n_ptr   = r_wr_idx;
                        n_state = i2a_pkg::S_FETCH;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            i2a_pkg::S_FETCH: begin
                n_state = i2a_pkg::S_EMIT;
            end
            i2a_pkg::S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    if (r_sign) begin
                        n_out_char = i2a_pkg::CHAR_MINUS;
                        n_out_last = 1'b0;
                        n_sign     = 1'b0;
                    end else begin
                        n_out_char = i2a_pkg::digit_char(r_rd_data, r_lower);
                        n_out_last = (r_ptr == '0);
                        if (r_ptr == '0) begin
                            n_state = i2a_pkg::S_IDLE;
                        end else begin
                            n_ptr = r_ptr - i2a_pkg::DIG_AW'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = i2a_pkg::S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= i2a_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_sign      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sign      <= n_sign;
        end
        r_wr_idx   <= n_wr_idx;
        r_ptr      <= n_ptr;
        r_base     <= n_base;
        r_lower    <= n_lower;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_idx] <= div_rem;
        end
        r_rd_data <= r_mem[n_ptr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_ascii_char = r_out_char;
    assign o_last_char  = r_out_last;

`include "assert_macros.svh"

    `ASSERT_PROP(a_busy_after_beat, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)
    `ASSERT_PROP(a_digit_below_base, i_clk, i_rst_n,
        (out_load && !r_sign) |-> (i2a_pkg::RADIX_W'(r_rd_data) < r_base))
    `ASSERT_PROP(a_sign_not_last, i_clk, i_rst_n,
        (r_out_valid && r_out_char == i2a_pkg::CHAR_MINUS) |-> !r_out_last)
    `ASSERT_NEVER(a_done_outside_div, i_clk, i_rst_n, div_done && (r_state != i2a_pkg::S_DIV))

endmodule

>>> src/i2a_divider.sv
`timescale 1ns / 1ps

module i2a_divider (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [i2a_pkg::VALUE_WIDTH-1:0]      i_dividend,
    input  logic [i2a_pkg::RADIX_W-1:0]          i_base,
    output logic                                 o_done,
    output logic [i2a_pkg::VALUE_WIDTH-1:0]      o_quotient,
    output logic [i2a_pkg::DIGIT_W-1:0]          o_remainder
);

    logic                               r_busy;
    logic                               n_busy;
    logic                               r_done;
    logic                               n_done;
    logic [i2a_pkg::DIV_W-1:0]          r_work;
    logic [i2a_pkg::DIV_W-1:0]          n_work;
    logic [i2a_pkg::DIGIT_W-1:0]        r_rem;
    logic [i2a_pkg::DIGIT_W-1:0]        n_rem;
    logic [i2a_pkg::RADIX_W-1:0]        r_base;
    logic [i2a_pkg::RADIX_W-1:0]        n_base;
    logic [i2a_pkg::DIV_CW-1:0]         r_cnt;
    logic [i2a_pkg::DIV_CW-1:0]         n_cnt;

    always_comb begin
        logic [i2a_pkg::DIGIT_W-1:0]    rem;
        logic [i2a_pkg::RADIX_W-1:0]    t;
        logic [i2a_pkg::DIV_STEP-1:0]   q;
        rem    = r_rem;
        q      = '0;
        for (int k = 0; k < i2a_pkg::DIV_STEP; k++) begin
            t = {rem, r_work[i2a_pkg::DIV_W-1-k]};
            if (t >= r_base) begin
                q[i2a_pkg::DIV_STEP-1-k] = 1'b1;
                rem = i2a_pkg::DIGIT_W'(t - r_base);
            end else begin
                rem = t[i2a_pkg::DIGIT_W-1:0];
            end
        end

        n_busy = r_busy;
        n_done = 1'b0;
        n_work = r_work;
        n_rem  = r_rem;
        n_base = r_base;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_work = i2a_pkg::DIV_W'(i_dividend);
            n_rem  = '0;
            n_base = i_base;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_work = (r_work << i2a_pkg::DIV_STEP) | i2a_pkg::DIV_W'(q);
            n_rem  = rem;
            n_cnt  = r_cnt + i2a_pkg::DIV_CW'(1);
            if (r_cnt == i2a_pkg::DIV_CW'(i2a_pkg::DIV_CHUNKS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_work <= n_work;
        r_rem  <= n_rem;
        r_base <= n_base;
        r_cnt  <= n_cnt;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_work[i2a_pkg::VALUE_WIDTH-1:0];
    assign o_remainder = r_rem;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic [i2a_pkg::IN_WIDTH-1:0] value;
        logic [i2a_pkg::RADIX_W-1:0]  radix;
        logic                         uns;
        logic                         lower;
    } t_num_req;

    typedef struct {
        logic [i2a_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } t_char_beat;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [i2a_pkg::IN_WIDTH-1:0]  i_value_bits = '0;
    logic [i2a_pkg::RADIX_W-1:0]   i_radix = '0;
    logic                          i_unsigned_mode = 1'b0;
    logic                          i_lower_case = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [i2a_pkg::CHAR_W-1:0]    o_ascii_char;
    logic                          o_last_char;

    t_num_req   pend_nums[$];
    t_char_beat exp_chars[$];
    int         err_cnt = 0;
    int         cyc = 0;
    int         out_beats = 0;
    int         rx_hold_left = 0;
    bit         rx_hold_done = 1'b0;
    logic       in_beat = 1'b0;

    integer_to_radix_ascii dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_value_bits    (i_value_bits),
        .i_radix         (i_radix),
        .i_unsigned_mode (i_unsigned_mode),
        .i_lower_case    (i_lower_case),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_ascii_char    (o_ascii_char),
        .o_last_char     (o_last_char)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit idle_now();
        if (cyc >= 10000 && cyc < 16000) begin
            return 1'b0;
        end
        return $urandom_range(99) < 32;
    endfunction

    function automatic void convert_to_chars(input t_num_req r);
        logic [i2a_pkg::VALUE_WIDTH-1:0] mag;
        logic [i2a_pkg::VALUE_WIDTH-1:0] base;
        logic [i2a_pkg::VALUE_WIDTH-1:0] d;
        logic [i2a_pkg::CHAR_W-1:0]      digs[$];
        logic                            neg;
        t_char_beat                      b;
        mag  = r.value[i2a_pkg::VALUE_WIDTH-1:0];
        base = (r.radix < 5'd2) ? 2 : (r.radix > 5'd16) ? 16
                                    : i2a_pkg::VALUE_WIDTH'(r.radix);
        neg  = !r.uns && mag[i2a_pkg::VALUE_WIDTH-1];
        if (neg) begin
            mag = -mag;
        end
        do begin
            d = mag % base;
            if (d < 10) begin
                digs.push_front(8'h30 + d[i2a_pkg::CHAR_W-1:0]);
            end else if (r.lower) begin
                digs.push_front(8'h61 + d[i2a_pkg::CHAR_W-1:0] - 8'd10);
            end else begin
                digs.push_front(8'h41 + d[i2a_pkg::CHAR_W-1:0] - 8'd10);
            end
            mag = mag / base;
        end while (mag != 0);
        if (neg) begin
            b.ch   = 8'h2D;
            b.last = 1'b0;
            exp_chars.push_back(b);
        end
        foreach (digs[i]) begin
            b.ch   = digs[i];
            b.last = (i == digs.size() - 1);
            exp_chars.push_back(b);
        end
    endfunction

    function automatic logic [i2a_pkg::IN_WIDTH-1:0] pick_value();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    2: return 32'h8000_0000;
                    3: return 32'h7FFF_FFFF;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2: return $urandom_range(255);
            3: return -$urandom_range(300, 1);
            4: return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_num(input logic [i2a_pkg::IN_WIDTH-1:0] v,
                           input logic [i2a_pkg::RADIX_W-1:0] r,
                           input logic uns, input logic lower);
        t_num_req n;
        n.value = v;
        n.radix = r;
        n.uns   = uns;
        n.lower = lower;
        pend_nums.push_back(n);
    endtask

    task automatic add_random(input int cnt);
        logic [i2a_pkg::RADIX_W-1:0] r;
        repeat (cnt) begin
            if ($urandom_range(9) == 0) begin
                r = i2a_pkg::RADIX_W'($urandom_range(31));
            end else begin
                r = i2a_pkg::RADIX_W'($urandom_range(16, 2));
            end
            add_num(pick_value(), r, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    task automatic wait_drained();
        while (pend_nums.size() != 0 || i_in_valid || exp_chars.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // sender: hold the beat until taken, then advance or idle
    always @(negedge i_clk) begin : drv
        t_num_req n;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_beat) begin
            if (pend_nums.size() != 0 && !idle_now()) begin
                n = pend_nums.pop_front();
                i_in_valid      <= 1'b1;
                i_value_bits    <= n.value;
                i_radix         <= n.radix;
                i_unsigned_mode <= n.uns;
                i_lower_case    <= n.lower;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            i_out_ready  <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (!rx_hold_done && out_beats >= 1000) begin
            rx_hold_done <= 1'b1;
            rx_hold_left <= 400;
            i_out_ready  <= 1'b0;
        end else begin
            i_out_ready <= !idle_now();
        end
    end

    always @(posedge i_clk) begin : mon
        t_num_req   n;
        t_char_beat e;
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            in_beat <= 1'b0;
        end else begin
            in_beat <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                n.value = i_value_bits;
                n.radix = i_radix;
                n.uns   = i_unsigned_mode;
                n.lower = i_lower_case;
                convert_to_chars(n);
            end
            if (o_out_valid && i_out_ready) begin
                out_beats <= out_beats + 1;
                if (exp_chars.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual char %h last %b",
                             $time, o_ascii_char, o_last_char);
                    err_cnt++;
                end else begin
                    e = exp_chars.pop_front();
                    if (o_ascii_char !== e.ch) begin
                        $display("%0t: ascii_char mismatch, expected %h, actual %h",
                                 $time, e.ch, o_ascii_char);
                        err_cnt++;
                    end
                    if (o_last_char !== e.last) begin
                        $display("%0t: last_char mismatch, expected %b, actual %b",
                                 $time, e.last, o_last_char);
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        add_num(32'h0000_0000, 5'd10, 1'b1, 1'b0);
        add_num(32'h0000_0000, 5'd2,  1'b0, 1'b1);
        add_num(32'hFFFF_FFFF, 5'd2,  1'b1, 1'b0);
        add_num(32'hFFFF_FFFF, 5'd2,  1'b0, 1'b0);
        add_num(32'h8000_0000, 5'd2,  1'b0, 1'b0);
        add_num(32'h8000_0000, 5'd16, 1'b0, 1'b1);
        add_num(32'h7FFF_FFFF, 5'd10, 1'b0, 1'b0);
        add_num(32'hDEAD_BEEF, 5'd0,  1'b1, 1'b1);
        add_num(32'hDEAD_BEEF, 5'd1,  1'b0, 1'b0);
        add_num(32'hCAFE_F00D, 5'd31, 1'b1, 1'b0);
        add_num(32'hCAFE_F00D, 5'd17, 1'b1, 1'b1);
        for (int r = 3; r <= 16; r++) begin
            add_num(32'hABCD_EF01 ^ r, i2a_pkg::RADIX_W'(r), r[0], r[1]);
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();
        add_random(150);
        wait_drained();
        add_random(155);
        wait_drained();
        repeat (200) @(negedge i_clk);
        if (err_cnt == 0 && exp_chars.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
